@@ hw/rtl/sdt_pkg.sv @@
// Shared types and constants for the seen-device table with report throttle.
// Used by every module of the block and by its port checker.
package sdt_pkg;

  localparam int MAC_W    = 48;
  localparam int TIME_W   = 32;
  localparam int RSSI_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int ACT_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RSSI_THRESHOLD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INTERVAL  = 2'd1;

  // Configuration reset values
  localparam logic signed [RSSI_W-1:0] RSSI_THRESHOLD_RESET = -8'sd80;
  localparam logic [TIME_W-1:0]        REPORT_INTERVAL_RESET = 32'd180000;

  // Outcome of one sighting
  typedef enum logic [ACT_W-1:0] {
    ACT_WEAK       = 3'd0,
    ACT_KNOWN_WAIT = 3'd1,
    ACT_KNOWN_DUE  = 3'd2,
    ACT_INSERT     = 3'd3,
    ACT_REPLACE    = 3'd4
  } action_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_DONE
  } state_t;

  // Operations of the shared compare unit
  typedef enum logic {
    CMP_LESS,     // a < b
    CMP_ELAPSED   // lim < (a - b), wrapped
  } cmp_op_t;

  typedef struct packed {
    cmp_op_t           op;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] lim;
  } cmp_req_t;

  // One entry as read back from the table
  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] stamp;
  } entry_rd_t;

endpackage

@@ hw/rtl/sdt_cmp.sv @@
// Shared time compare unit: unsigned less-than, or wrapped elapsed time
// against a limit. Depends on sdt_pkg.
module sdt_cmp (
  input  sdt_pkg::cmp_req_t req,
  output logic              hit
);
  import sdt_pkg::*;

  logic [TIME_W-1:0] diff;

  // Subtract modulo 2^32, then compare on the selected operands
  always_comb begin
    diff = req.a - req.b;
    unique case (req.op)
      CMP_LESS:    hit = req.a < req.b;
      CMP_ELAPSED: hit = req.lim < diff;
      default:     hit = 1'b0;
    endcase
  end

endmodule

@@ hw/rtl/sdt_store.sv @@
// Entry table: address and time memory with one write and one registered
// read port, plus per-entry valid flops cleared at reset. Depends on sdt_pkg.
module sdt_store #(
  parameter int ENTRIES = 16,
  parameter int IW      = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [IW-1:0]             rd_idx,
  output sdt_pkg::entry_rd_t        rd_data,
  input  logic                      wr_en,
  input  logic [IW-1:0]             wr_idx,
  input  logic [sdt_pkg::MAC_W-1:0] wr_mac,
  input  logic [sdt_pkg::TIME_W-1:0] wr_stamp
);
  import sdt_pkg::*;

  logic [MAC_W-1:0]  mem_mac   [ENTRIES];
  logic [TIME_W-1:0] mem_stamp [ENTRIES];
  logic [ENTRIES-1:0] valid;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_mac[wr_idx]   <= wr_mac;
      mem_stamp[wr_idx] <= wr_stamp;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data.mac   <= mem_mac[rd_idx];
      rd_data.stamp <= mem_stamp[rd_idx];
      rd_data.valid <= valid[rd_idx];
    end
  end

endmodule

@@ hw/rtl/seen_device_table_with_report_throttle_top.sv @@
// Seen-device table with report throttle, top level: config registers,
// scan sequencer and output register. Depends on sdt_pkg, sdt_store, sdt_cmp.
//
// One sighting is taken at a time and gives exactly one result beat. A weak
// sighting goes straight from accept to the result stage; any other first
// walks the table's single read port, one entry per cycle, with the shared
// compare unit checking each entry's time against the oldest so far and then
// the elapsed time against the interval before its result stage. in_stall is
// high from accept until the result is loaded into the output register; the
// next sighting can enter while that result waits.
// Configuration writes are always taken (cfg_ready is high); write them only
// while no sighting is in flight. No clearing pass is needed after reset.
module seen_device_table_with_report_throttle_top #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // sighting channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [sdt_pkg::MAC_W-1:0]       mac_address,
  input  logic signed [sdt_pkg::RSSI_W-1:0] rssi,
  input  logic [sdt_pkg::TIME_W-1:0]      now_ms,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            report,
  output logic [sdt_pkg::MAC_W-1:0]       report_mac,
  output logic [sdt_pkg::ACT_W-1:0]       action,
  output logic [sdt_pkg::SLOT_W-1:0]      slot,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sdt_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW:0]   CNT_END  = (IW + 1)'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // Configuration registers
  logic signed [RSSI_W-1:0] rssi_threshold;
  logic [TIME_W-1:0]        report_interval_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rssi_threshold     <= RSSI_THRESHOLD_RESET;
      report_interval_ms <= REPORT_INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RSSI_THRESHOLD:  rssi_threshold     <= cfg_data[RSSI_W-1:0];
        REG_REPORT_INTERVAL: report_interval_ms <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and scan registers
  state_t            state, state_next;
  logic [IW:0]       cnt, cnt_next;
  logic              pend, pend_next;
  logic [IW-1:0]     pidx, pidx_next;
  logic [MAC_W-1:0]  mac_r, mac_r_next;
  logic [TIME_W-1:0] now_r, now_r_next;
  logic              found, found_next;
  logic [IW-1:0]     found_idx, found_idx_next;
  logic [TIME_W-1:0] found_time, found_time_next;
  logic              free_ok, free_ok_next;
  logic [IW-1:0]     free_idx, free_idx_next;
  logic              old_ok, old_ok_next;
  logic [IW-1:0]     old_idx, old_idx_next;
  logic [TIME_W-1:0] old_time, old_time_next;
  action_t           res_act, res_act_next;
  logic [IW-1:0]     res_idx, res_idx_next;

  // Output register
  logic              out_valid_next;
  logic              report_next;
  logic [MAC_W-1:0]  report_mac_next;
  logic [ACT_W-1:0]  action_next;
  logic [SLOT_W-1:0] slot_next;

  // Table and compare unit hookup
  logic        rd_en;
  logic [IW-1:0] rd_idx;
  entry_rd_t   rd_data;
  logic        wr_en;
  cmp_req_t    cmp_req;
  logic        cmp_hit;
  logic        out_free;

  sdt_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_idx   (res_idx),
    .wr_mac   (mac_r),
    .wr_stamp (now_r)
  );

  sdt_cmp u_cmp (
    .req (cmp_req),
    .hit (cmp_hit)
  );

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      found     <= 1'b0;
      free_ok   <= 1'b0;
      old_ok    <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      pend      <= pend_next;
      found     <= found_next;
      free_ok   <= free_ok_next;
      old_ok    <= old_ok_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt        <= cnt_next;
    pidx       <= pidx_next;
    mac_r      <= mac_r_next;
    now_r      <= now_r_next;
    found_idx  <= found_idx_next;
    found_time <= found_time_next;
    free_idx   <= free_idx_next;
    old_idx    <= old_idx_next;
    old_time   <= old_time_next;
    res_act    <= res_act_next;
    res_idx    <= res_idx_next;
    report     <= report_next;
    report_mac <= report_mac_next;
    action     <= action_next;
    slot       <= slot_next;
  end

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pend_next       = 1'b0;
    pidx_next       = pidx;
    mac_r_next      = mac_r;
    now_r_next      = now_r;
    found_next      = found;
    found_idx_next  = found_idx;
    found_time_next = found_time;
    free_ok_next    = free_ok;
    free_idx_next   = free_idx;
    old_ok_next     = old_ok;
    old_idx_next    = old_idx;
    old_time_next   = old_time;
    res_act_next    = res_act;
    res_idx_next    = res_idx;
    out_valid_next  = out_valid && out_stall;
    report_next     = report;
    report_mac_next = report_mac;
    action_next     = action;
    slot_next       = slot;
    rd_en           = 1'b0;
    rd_idx          = cnt[IW-1:0];
    wr_en           = 1'b0;
    cmp_req.op      = CMP_LESS;
    cmp_req.a       = rd_data.stamp;
    cmp_req.b       = old_time;
    cmp_req.lim     = report_interval_ms;

    unique case (state)
      ST_IDLE: begin
        // Take a sighting; reject weak ones at once
        if (in_valid) begin
          mac_r_next   = mac_address;
          now_r_next   = now_ms;
          found_next   = 1'b0;
          free_ok_next = 1'b0;
          old_ok_next  = 1'b0;
          cnt_next     = '0;
          if (rssi < rssi_threshold) begin
            res_act_next = ACT_WEAK;
            res_idx_next = '0;
            state_next   = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle
        if (cnt < CNT_END) begin
          rd_en     = 1'b1;
          cnt_next  = cnt + 1'b1;
          pend_next = 1'b1;
          pidx_next = cnt[IW-1:0];
        end
        // Check the entry read last cycle
        if (pend) begin
          if (rd_data.valid) begin
            if (!found && rd_data.mac == mac_r) begin
              found_next      = 1'b1;
              found_idx_next  = pidx;
              found_time_next = rd_data.stamp;
            end
            if (!old_ok || cmp_hit) begin
              old_ok_next   = 1'b1;
              old_idx_next  = pidx;
              old_time_next = rd_data.stamp;
            end
          end else if (!free_ok) begin
            free_ok_next  = 1'b1;
            free_idx_next = pidx;
          end
          if (pidx == LAST_IDX) begin
            pend_next  = 1'b0;
            state_next = ST_EVAL;
          end
        end
      end

      ST_EVAL: begin
        // Decide the outcome; elapsed check uses the shared unit
        cmp_req.op = CMP_ELAPSED;
        cmp_req.a  = now_r;
        cmp_req.b  = found_time;
        if (found) begin
          res_idx_next = found_idx;
          res_act_next = cmp_hit ? ACT_KNOWN_DUE : ACT_KNOWN_WAIT;
        end else if (free_ok) begin
          res_idx_next = free_idx;
          res_act_next = ACT_INSERT;
        end else begin
          res_idx_next = old_idx;
          res_act_next = ACT_REPLACE;
        end
        state_next = ST_DONE;
      end

      ST_DONE: begin
        // Load the result beat and, for a reported sighting, write back the entry
        if (out_free) begin
          out_valid_next  = 1'b1;
          report_mac_next = mac_r;
          action_next     = res_act;
          slot_next       = SLOT_W'(res_idx);
          report_next     = (res_act == ACT_KNOWN_DUE) || (res_act == ACT_INSERT) ||
                            (res_act == ACT_REPLACE);
          wr_en           = report_next;
          state_next      = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/sdt_checker.sv @@
// Port checker for the seen-device table top level, bound in below.
// Depends on sdt_pkg.
module sdt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          report,
  input logic [sdt_pkg::MAC_W-1:0]     report_mac,
  input logic [sdt_pkg::ACT_W-1:0]     action,
  input logic [sdt_pkg::SLOT_W-1:0]    slot
);
  import sdt_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(report_mac) && $stable(action))
    else $error("stalled result beat changed");

  // Stay busy right after a sighting is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second sighting taken while one is in flight");

  // Report only for refreshed, inserted or replaced entries
  a_report_action: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> report == (action == ACT_KNOWN_DUE || action == ACT_INSERT ||
                             action == ACT_REPLACE))
    else $error("report flag disagrees with action");

  // Rejected sightings point at slot zero
  a_weak_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_WEAK |-> slot == '0)
    else $error("rejected sighting carries a slot");

endmodule

bind seen_device_table_with_report_throttle_top sdt_checker u_sdt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .report     (report),
  .report_mac (report_mac),
  .action     (action),
  .slot       (slot)
);

@@ tb/seen_device_table_with_report_throttle_top_test.sv @@
// Self-checking bench for seen_device_table_with_report_throttle_top: directed probes, then
// random sightings over several register settings, checked against a table predictor.
// Depends on sdt_pkg and the RTL of the block only.
module seen_device_table_with_report_throttle_top_test;
  import sdt_pkg::*;

  localparam int ENTRIES = 16;
  localparam int PHASES = 7;
  localparam int PHASE_SIGHTINGS = 290;
  localparam int LONG_HOLD = 300;
  localparam int POOL = 24;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct {
    bit                report;
    logic [MAC_W-1:0]  mac;
    action_t           action;
    logic [SLOT_W-1:0] slot;
  } sighting_result_t;

  typedef struct {
    logic [MAC_W-1:0]         mac;
    logic signed [RSSI_W-1:0] strength;
    logic [TIME_W-1:0]        now;
    bit                       fixed;
    bit                       report;
    action_t                  action;
    logic [SLOT_W-1:0]        slot;
  } probe_row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [MAC_W-1:0]         mac_address;
  logic signed [RSSI_W-1:0] rssi;
  logic [TIME_W-1:0]        now_ms;
  logic                     out_valid;
  logic                     out_stall;
  logic                     report;
  logic [MAC_W-1:0]         report_mac;
  logic [ACT_W-1:0]         action;
  logic [SLOT_W-1:0]        slot;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;

  // predictor copy of the table and the registers
  bit                       slot_used [ENTRIES];
  logic [MAC_W-1:0]         slot_mac [ENTRIES];
  logic [TIME_W-1:0]        slot_stamp [ENTRIES];
  logic signed [RSSI_W-1:0] min_rssi;
  logic [TIME_W-1:0]        recheck_ms;

  sighting_result_t outcome_q [$];
  probe_row_t       probe_list [$];
  logic [MAC_W-1:0] mac_pool [POOL];
  logic [TIME_W-1:0] wall_ms;

  int  in_gap_max;
  int  out_gap_max;
  int  sink_wait;
  bit  hold_on;
  int  sightings_taken;
  int  strong_taken;
  int  results_checked;
  int  mismatches;
  int  act_count [5];

  seen_device_table_with_report_throttle_top #(.ENTRIES(ENTRIES)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mac_address(mac_address), .rssi(rssi), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .report(report), .report_mac(report_mac), .action(action), .slot(slot),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Look up one sighting, update the predicted table and return its outcome
  function automatic sighting_result_t track_sighting(input logic [MAC_W-1:0] mac,
      input logic signed [RSSI_W-1:0] strength, input logic [TIME_W-1:0] now);
    sighting_result_t res;
    int hit;
    int vacant;
    int eldest;
    int pick;
    logic [TIME_W-1:0] eldest_t;
    logic [TIME_W-1:0] elapsed;
    res.report = 1'b0;
    res.mac = mac;
    res.action = ACT_WEAK;
    res.slot = '0;
    hit = -1;
    vacant = -1;
    eldest = -1;
    eldest_t = '0;
    if (strength >= min_rssi) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_used[i]) begin
          if (hit < 0 && slot_mac[i] == mac) hit = i;
          if (eldest < 0 || slot_stamp[i] < eldest_t) begin
            eldest = i;
            eldest_t = slot_stamp[i];
          end
        end else if (vacant < 0) begin
          vacant = i;
        end
      end
      if (hit >= 0) begin
        res.slot = hit[SLOT_W-1:0];
        elapsed = now - slot_stamp[hit];
        if (elapsed > recheck_ms) begin
          slot_stamp[hit] = now;
          res.report = 1'b1;
          res.action = ACT_KNOWN_DUE;
        end else begin
          res.action = ACT_KNOWN_WAIT;
        end
      end else begin
        if (vacant >= 0) begin
          pick = vacant;
          res.action = ACT_INSERT;
        end else begin
          pick = (eldest >= 0) ? eldest : 0;
          res.action = ACT_REPLACE;
        end
        slot_used[pick] = 1'b1;
        slot_mac[pick] = mac;
        slot_stamp[pick] = now;
        res.slot = pick[SLOT_W-1:0];
        res.report = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[MAC_W-1:0];
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d, %s: expected %h, got %h", results_checked, what, want, got);
  endtask

  task automatic add_probe(input logic [MAC_W-1:0] mac, input logic signed [RSSI_W-1:0] strength,
      input logic [TIME_W-1:0] now, input bit fixed, input bit rep, input action_t act,
      input logic [SLOT_W-1:0] where);
    probe_row_t row;
    row.mac = mac;
    row.strength = strength;
    row.now = now;
    row.fixed = fixed;
    row.report = rep;
    row.action = act;
    row.slot = where;
    probe_list.push_back(row);
  endtask

  // Offer one sighting beat after a random gap and record its predicted outcome
  task automatic send_sighting(input logic [MAC_W-1:0] mac,
      input logic signed [RSSI_W-1:0] strength, input logic [TIME_W-1:0] now,
      input bit fixed, input bit rep, input action_t act, input logic [SLOT_W-1:0] where);
    int gap;
    sighting_result_t want;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    mac_address = mac;
    rssi = strength;
    now_ms = now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = track_sighting(mac, strength, now);
    if (want.action != ACT_WEAK) strong_taken++;
    if (fixed) begin
      want.report = rep;
      want.action = act;
      want.slot = where;
    end
    outcome_q.push_back(want);
    sightings_taken++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_RSSI_THRESHOLD:  min_rssi = value[RSSI_W-1:0];
      REG_REPORT_INTERVAL: recheck_ms = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
    @(negedge clk);
  endtask

  // Wait for every predicted result, then let the block settle
  task automatic drain(input int extra);
    while (outcome_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Random sightings: mostly pooled addresses so entries match, expire and get replaced
  task automatic run_traffic(input int strong_goal);
    int passed;
    int pick;
    int thr;
    int live [$];
    int k;
    logic [MAC_W-1:0] mac;
    logic signed [RSSI_W-1:0] strength;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] adv;
    passed = 0;
    foreach (mac_pool[i])
      mac_pool[i] = (i == 0) ? '0 : (i == 1) ? '1 : rand_mac();
    while (passed < strong_goal) begin
      live.delete();
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i]) live.push_back(i);
      if (recheck_ms > 32'd100_000_000) adv = $urandom;
      else adv = $urandom_range(0, recheck_ms / 3 + 4);
      wall_ms = wall_ms + adv;
      pick = $urandom_range(0, 9);
      if (pick <= 1 && live.size() > 0) begin
        // land right on the interval boundary of a stored entry
        k = live[$urandom_range(0, live.size() - 1)];
        mac = slot_mac[k];
        now = slot_stamp[k] + recheck_ms + $urandom_range(0, 1);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 7) mac = mac_pool[$urandom_range(0, POOL - 1)];
        else if (pick < 9 || live.size() == 0) mac = rand_mac();
        else mac = slot_mac[live[$urandom_range(0, live.size() - 1)]];
        pick = $urandom_range(0, 9);
        if (pick < 7) now = wall_ms;
        else if (pick == 7) now = $urandom;
        else if (pick == 8) now = wall_ms - $urandom_range(0, 5000);
        else now = wall_ms + 32'h8000_0000;
      end
      thr = int'(min_rssi);
      pick = $urandom_range(0, 9);
      if (pick < 8) strength = 8'(thr + $urandom_range(0, 127 - thr));
      else if (pick == 8 || thr == -128) strength = 8'(thr);
      else strength = 8'(-128 + $urandom_range(0, thr + 127));
      if (strength >= min_rssi) passed++;
      send_sighting(mac, strength, now, 1'b0, 1'b0, ACT_WEAK, '0);
    end
    in_valid = 1'b0;
  endtask

  // Receiver: random stall per result beat, plus the long hold when it is on
  initial begin : result_sink
    out_stall = 1'b0;
    sink_wait = 0;
    forever begin
      @(negedge clk);
      out_stall = (hold_on || sink_wait > 0);
      if (!hold_on && sink_wait > 0) sink_wait--;
    end
  end

  // Hold the output off for a long stretch so the block backs up into its input
  initial begin : long_hold
    hold_on = 1'b0;
    wait (sightings_taken >= 500);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    hold_on = 1'b0;
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin : result_check
    sighting_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        flag_mismatch("result with no sighting pending", '0, 64'(report_mac));
      end else begin
        want = outcome_q.pop_front();
        if (report !== want.report) flag_mismatch("report", 64'(want.report), 64'(report));
        if (report_mac !== want.mac) flag_mismatch("report_mac", 64'(want.mac), 64'(report_mac));
        if (action !== want.action) flag_mismatch("action", 64'(want.action), 64'(action));
        if (slot !== want.slot) flag_mismatch("slot", 64'(want.slot), 64'(slot));
        act_count[int'(want.action)]++;
      end
      results_checked++;
      sink_wait = $urandom_range(0, out_gap_max);
    end
  end

  initial begin : watchdog
    #2_500_000;
    $display("timeout with %0d results still pending", outcome_q.size());
    $display("seen_device_table_with_report_throttle_top verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [MAC_W-1:0] fill_mac;
    rst = 1'b1;
    in_valid = 1'b0;
    mac_address = '0;
    rssi = '0;
    now_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_gap_max = 9;
    out_gap_max = 9;
    sightings_taken = 0;
    strong_taken = 0;
    results_checked = 0;
    mismatches = 0;
    foreach (act_count[i]) act_count[i] = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    min_rssi = RSSI_THRESHOLD_RESET;
    recheck_ms = REPORT_INTERVAL_RESET;
    wall_ms = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed probes at reset settings: threshold -80, interval 180000
    add_probe('0, -8'sd128, '0, 1'b1, 1'b0, ACT_WEAK, 4'd0);
    add_probe('1, 8'sd127, 32'hFFFF_FFFF, 1'b1, 1'b1, ACT_INSERT, 4'd0);
    add_probe('0, -8'sd80, '0, 1'b1, 1'b1, ACT_INSERT, 4'd1);            // equal to threshold
    add_probe('0, -8'sd81, 32'd5, 1'b1, 1'b0, ACT_WEAK, 4'd0);
    add_probe('0, -8'sd80, 32'd180000, 1'b1, 1'b0, ACT_KNOWN_WAIT, 4'd1); // elapsed equals interval
    add_probe('0, 8'sd0, 32'd180001, 1'b1, 1'b1, ACT_KNOWN_DUE, 4'd1);
    add_probe('1, 8'sd10, 32'd179999, 1'b1, 1'b0, ACT_KNOWN_WAIT, 4'd0); // wrapped elapsed
    add_probe('1, 8'sd10, 32'd180000, 1'b1, 1'b1, ACT_KNOWN_DUE, 4'd0);
    // fill the rest; slots 5 and 9 tie for the oldest time
    for (int k = 2; k < ENTRIES; k++) begin
      fill_mac = (k == 2) ? 48'hAAAA_AAAA_AAAA :
                 (k == 3) ? 48'h5555_5555_5555 : 48'h0123_4567_8900 + k;
      add_probe(fill_mac, 8'(-80 + k * 13), (k == 5 || k == 9) ? 32'd100 : 32'd200000 + k,
                1'b1, 1'b1, ACT_INSERT, SLOT_W'(k));
    end
    add_probe(48'h8000_0000_0001, 8'sd127, 32'd300000, 1'b1, 1'b1, ACT_REPLACE, 4'd5);
    add_probe(48'h7FFF_FFFF_FFFE, -8'sd80, 32'd300001, 1'b1, 1'b1, ACT_REPLACE, 4'd9);
    add_probe('1, 8'sd50, 32'd300002, 1'b0, 1'b0, ACT_WEAK, 4'd0);
    foreach (probe_list[i])
      send_sighting(probe_list[i].mac, probe_list[i].strength, probe_list[i].now,
                    probe_list[i].fixed, probe_list[i].report, probe_list[i].action,
                    probe_list[i].slot);
    in_valid = 1'b0;
    wall_ms = 32'd300002;

    // Random phases, each with its own register setting and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      drain(4);
      case (ph)
        0: begin in_gap_max = 9; out_gap_max = 9; end
        1: begin
          write_reg(REG_RSSI_THRESHOLD, 32'hFFFF_FF80);
          write_reg(REG_REPORT_INTERVAL, 32'd0);
          in_gap_max = 9; out_gap_max = 0;
        end
        2: begin
          write_reg(REG_RSSI_THRESHOLD, 32'h0000_007F);
          write_reg(REG_REPORT_INTERVAL, 32'hFFFF_FFFF);
          write_reg(REG_SPARE_2, $urandom);
          write_reg(REG_SPARE_3, $urandom);
          in_gap_max = 0; out_gap_max = 9;
        end
        3: begin
          write_reg(REG_RSSI_THRESHOLD, 32'h1234_5600);
          write_reg(REG_REPORT_INTERVAL, 32'd1000);
          in_gap_max = 9; out_gap_max = 9;
        end
        4: begin
          write_reg(REG_RSSI_THRESHOLD, $urandom);
          write_reg(REG_REPORT_INTERVAL, $urandom_range(0, 200000));
          in_gap_max = 0; out_gap_max = 0;
        end
        5: begin
          write_reg(REG_RSSI_THRESHOLD, 32'(unsigned'(RSSI_THRESHOLD_RESET)));
          write_reg(REG_REPORT_INTERVAL, REPORT_INTERVAL_RESET);
          in_gap_max = 9; out_gap_max = 0;
        end
        default: begin
          write_reg(REG_RSSI_THRESHOLD, $urandom);
          write_reg(REG_REPORT_INTERVAL, $urandom);
          in_gap_max = 9; out_gap_max = 9;
        end
      endcase
      run_traffic(PHASE_SIGHTINGS);
    end

    drain(40);
    $display("%0d sightings sent, %0d past the strength check, %0d results checked, %0d mismatches",
             sightings_taken, strong_taken, results_checked, mismatches);
    $display("outcomes: rejected %0d, not due %0d, refreshed %0d, inserted %0d, replaced %0d",
             act_count[0], act_count[1], act_count[2], act_count[3], act_count[4]);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("seen_device_table_with_report_throttle_top verification clean");
    end else begin
      $display("seen_device_table_with_report_throttle_top verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sdt_pkg.sv
hw/rtl/sdt_cmp.sv
hw/rtl/sdt_store.sv
hw/rtl/seen_device_table_with_report_throttle_top.sv
hw/rtl/sdt_checker.sv
tb/seen_device_table_with_report_throttle_top_test.sv
